// File: sv/xfr_pkg.sv
`timescale 1ns / 1ps

package xfr_pkg;

  localparam int BUFFER_SIZE_DEF = 64;

  localparam int BYTE_W = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHECKSUM_SEED = 1'd1;

  localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'd170;
  localparam logic [BYTE_W-1:0] CHECKSUM_SEED_RST = 8'd0;

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_DATA  = 2'd1,
    PH_CHECK = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_FRAME_OK  = 2'd0,
    ST_CSUM_ERR  = 2'd1,
    ST_LEN_OVF   = 2'd2,
    ST_NO_START  = 2'd3
  } status_t;

  typedef struct packed {
    status_t           status;
    logic [BYTE_W-1:0] rx_length;
    logic [BYTE_W-1:0] checksum_value;
  } result_t;

endpackage

// File: sv/xfr_core.sv
`timescale 1ns / 1ps

module xfr_core import xfr_pkg::*; #(
  parameter int BUFFER_SIZE = BUFFER_SIZE_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_wdata,
  input  logic                 step,
  input  logic [BYTE_W-1:0]    rx_byte,
  input  logic                 restart,
  output logic                 res_valid,
  output result_t              res
);

  localparam int OFF_W = $clog2(BUFFER_SIZE);

  logic [BYTE_W-1:0] start_byte_r;
  logic [BYTE_W-1:0] seed_r;

  phase_t            phase_r, phase_nxt;
  logic [OFF_W-1:0]  offset_r, offset_nxt;
  logic [BYTE_W-1:0] length_r, length_nxt;
  logic [BYTE_W-1:0] xor_r, xor_nxt;

  phase_t            phase_eff;
  logic [OFF_W-1:0]  offset_eff;
  logic [OFF_W:0]    offset_inc;
  logic              last_data;
  logic              overflow;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= START_BYTE_RST;
      seed_r       <= CHECKSUM_SEED_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_START_BYTE:    start_byte_r <= cfg_wdata;
        CFG_CHECKSUM_SEED: seed_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // A restart word drops any frame in progress before the byte is looked at.
  assign phase_eff  = restart ? PH_HUNT : phase_r;
  assign offset_eff = restart ? '0 : offset_r;
  assign offset_inc = (OFF_W+1)'(offset_eff) + (OFF_W+1)'(1);
  assign last_data  = (BYTE_W'(offset_eff) == length_nxt);
  assign overflow   = !last_data && (offset_inc >= (OFF_W+1)'(BUFFER_SIZE));

  // Next state.
  always_comb begin
    phase_nxt  = phase_r;
    offset_nxt = offset_r;
    length_nxt = length_r;
    xor_nxt    = xor_r;
    unique case (phase_eff)
      PH_DATA: begin
        if (offset_eff == OFF_W'(1)) begin
          length_nxt = rx_byte;
        end else begin
          xor_nxt = xor_r ^ rx_byte;
        end
        if (last_data) begin
          phase_nxt  = PH_CHECK;
          offset_nxt = offset_inc[OFF_W-1:0];
        end else if (overflow) begin
          phase_nxt  = PH_HUNT;
          offset_nxt = '0;
        end else begin
          phase_nxt  = PH_DATA;
          offset_nxt = offset_inc[OFF_W-1:0];
        end
      end
      PH_CHECK: begin
        phase_nxt  = PH_HUNT;
        offset_nxt = '0;
      end
      default: begin
        if (rx_byte == start_byte_r) begin
          phase_nxt  = PH_DATA;
          offset_nxt = OFF_W'(1);
          xor_nxt    = seed_r;
        end else begin
          phase_nxt  = PH_HUNT;
          offset_nxt = '0;
        end
      end
    endcase
  end

  // Result of the word being handled.
  always_comb begin
    res_valid          = 1'b0;
    res.status         = ST_NO_START;
    res.rx_length      = '0;
    res.checksum_value = '0;
    unique case (phase_eff)
      PH_DATA: begin
        res_valid          = overflow;
        res.status         = ST_LEN_OVF;
        res.rx_length      = length_nxt;
        res.checksum_value = xor_nxt;
      end
      PH_CHECK: begin
        res_valid          = 1'b1;
        res.status         = (rx_byte == xor_r) ? ST_FRAME_OK : ST_CSUM_ERR;
        res.rx_length      = length_r;
        res.checksum_value = xor_r;
      end
      default: begin
        res_valid = (rx_byte != start_byte_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      offset_r <= '0;
      length_r <= '0;
      xor_r    <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      offset_r <= offset_nxt;
      length_r <= length_nxt;
      xor_r    <= xor_nxt;
    end
  end

endmodule

// File: sv/xfr_out_reg.sv
`timescale 1ns / 1ps

module xfr_out_reg import xfr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  result_t           res,
  input  logic              out_stall,
  output logic              free,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [BYTE_W-1:0] out_rx_length,
  output logic [BYTE_W-1:0] out_checksum_value
);

  logic    valid_r;
  result_t res_r;

  // The slot can take a new word when empty or when its word leaves now.
  assign free = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      res_r <= res;
    end
  end

  assign out_valid          = valid_r;
  assign out_status         = res_r.status;
  assign out_rx_length      = res_r.rx_length;
  assign out_checksum_value = res_r.checksum_value;

endmodule

// File: sv/xor_frame_receiver.sv
`timescale 1ns / 1ps

// Length-prefixed frame receiver with an XOR checksum.
// Input channel: one received word (in_rx_byte plus in_restart) is taken at
// each edge with in_valid high and in_stall low. Output channel: one status
// word (out_status, out_rx_length, out_checksum_value) is delivered at each
// edge with out_valid high and out_stall low. Not every input word gives a
// status word: start, length and frame bytes give none but on buffer overflow.
// Configuration: cfg_wr_en writes cfg_wdata to start byte (index 0) or
// checksum seed (index 1); write only while no word is in flight.
// Path: a taken word waits in the input register and is parsed as it leaves
// it; its status is loaded into the output register at that same edge.
// Throughput: one word per cycle while in_stall is low.
// Stall: while the output register holds a status word that the receiver
// stalls, in_stall is high whenever the input register holds a word, even one
// that gives no status; the input register then keeps that word.
// Reset (synchronous, rst_n low): parser hunts for the start byte, both
// registers are empty, start byte returns to 170 and the seed to 0.

module xor_frame_receiver import xfr_pkg::*; #(
  parameter int BUFFER_SIZE = BUFFER_SIZE_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_W-1:0]    in_rx_byte,
  input  logic                 in_restart,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_status,
  output logic [BYTE_W-1:0]    out_rx_length,
  output logic [BYTE_W-1:0]    out_checksum_value
);

  logic              in_valid_r;
  logic [BYTE_W-1:0] rx_byte_r;
  logic              restart_r;

  logic    out_free;
  logic    step;
  logic    res_valid;
  result_t res;

  assign step     = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      rx_byte_r <= in_rx_byte;
      restart_r <= in_restart;
    end
  end

  xfr_core #(
    .BUFFER_SIZE(BUFFER_SIZE)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .rx_byte   (rx_byte_r),
    .restart   (restart_r),
    .res_valid (res_valid),
    .res       (res)
  );

  xfr_out_reg u_out_reg (
    .clk                (clk),
    .rst_n              (rst_n),
    .load               (step && res_valid),
    .res                (res),
    .out_stall          (out_stall),
    .free               (out_free),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_rx_length      (out_rx_length),
    .out_checksum_value (out_checksum_value)
  );

endmodule
